// ----- sv/scalar_kalman_filter_unit_defines.svh -----
// Assertion helpers, sampled on i_clk and disabled while i_rst_n is low.
`ifndef SCALAR_KALMAN_FILTER_UNIT_DEFINES_SVH
`define SCALAR_KALMAN_FILTER_UNIT_DEFINES_SVH

// Condition must hold at every clock edge.
`define SKF_ASSERT_ALWAYS(label, cond, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (cond)) else $error(msg);

// Antecedent implies consequent in the same cycle.
`define SKF_ASSERT_IMP(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

`endif

// ----- sv/skf_pkg.sv -----
package skf_pkg;

    localparam int DATA_W      = 32;
    localparam int GAIN_BITS   = 16;
    localparam int GAIN_W      = GAIN_BITS + 1;
    localparam logic [GAIN_W-1:0] GAIN_ONE = GAIN_W'(1) << GAIN_BITS;

    localparam int IN_TDATA_W  = 32;
    localparam int OUT_TDATA_W = 88;

    localparam int CFG_IDX_W   = 2;
    localparam logic [CFG_IDX_W-1:0] REG_INIT_EST  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_INIT_COV  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_PROC_NOISE = 2'd2;
    localparam logic [CFG_IDX_W-1:0] REG_MEAS_NOISE = 2'd3;

    localparam logic [DATA_W-1:0] RST_INIT_EST   = 32'd0;
    localparam logic [DATA_W-1:0] RST_INIT_COV   = 32'd65536;
    localparam logic [DATA_W-1:0] RST_PROC_NOISE = 32'd6554;
    localparam logic [DATA_W-1:0] RST_MEAS_NOISE = 32'd65536;

    localparam int MUL_A_W = DATA_W + 2;
    localparam int MUL_B_W = GAIN_W + 1;
    localparam int MUL_P_W = MUL_A_W + MUL_B_W;

    typedef struct packed {
        logic              start;
        logic [DATA_W-1:0] num;
        logic [DATA_W:0]   den;
    } t_div_req;

endpackage

// ----- sv/scalar_kalman_filter_unit.sv -----
// Scalar Kalman filter, constant-state model, Q16.16 values with a Q1.16 gain.
// One sample is accepted, then the unit is busy and takes no new sample: one
// predict state, one divider setup state, the restoring divider (17 gain
// bits, one per cycle, then a done strobe), two passes through the shared
// 34x18 multiplier and one write-back state; the next sample is taken in the
// cycle after write-back at the earliest.
// The result sits in an output register, so a new sample can be accepted while
// the previous result waits; write-back stalls only if that result is still
// not taken. Any configuration write reloads the estimate and covariance from
// the initial registers.
`include "scalar_kalman_filter_unit_defines.svh"

module scalar_kalman_filter_unit (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_s_axis_tvalid,
    output logic                               o_s_axis_tready,
    // [31:0] sample
    input  logic [skf_pkg::IN_TDATA_W-1:0]     i_s_axis_tdata,
    output logic                               o_m_axis_tvalid,
    input  logic                               i_m_axis_tready,
    // [31:0] estimate, [63:32] covariance, [80:64] gain, [87:81] zero
    output logic [skf_pkg::OUT_TDATA_W-1:0]    o_m_axis_tdata,
    input  logic                               i_cfg_we,
    input  logic [skf_pkg::CFG_IDX_W-1:0]      i_cfg_idx,
    input  logic [skf_pkg::DATA_W-1:0]         i_cfg_data
);
    import skf_pkg::*;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_PRED,
        ST_GO,
        ST_DIV,
        ST_MUL1,
        ST_MUL2,
        ST_FIN
    } t_state;

    t_state r_state;

    logic [DATA_W-1:0] r_init_est;
    logic [DATA_W-1:0] r_init_cov;
    logic [DATA_W-1:0] r_proc_noise;
    logic [DATA_W-1:0] r_meas_noise;
    logic [DATA_W-1:0] r_x;
    logic [DATA_W-1:0] r_p;
    logic [DATA_W-1:0] r_sample;
    logic [DATA_W-1:0] r_p1;
    logic [GAIN_W-1:0] r_gain;
    logic [DATA_W-1:0] r_x_new;
    logic              r_out_valid;
    logic [OUT_TDATA_W-1:0] r_out_data;

    logic [DATA_W:0]   w_p1_sum;
    logic [DATA_W-1:0] w_p1_sat;
    logic [DATA_W:0]   w_diff;
    t_div_req          w_div_req;
    logic              w_div_done;
    logic [GAIN_W-1:0] w_div_quot;
    logic signed [MUL_A_W-1:0] w_mul_a;
    logic signed [MUL_B_W-1:0] w_mul_b;
    logic signed [MUL_P_W-1:0] w_mul_p;
    logic [DATA_W-1:0] w_p_new;
    logic              w_in_accept;
    logic              w_out_fire;

    assign w_p1_sum = {1'b0, r_p} + {1'b0, r_proc_noise};
    assign w_p1_sat = w_p1_sum[DATA_W] ? '1 : w_p1_sum[DATA_W-1:0];
    assign w_diff   = {r_sample[DATA_W-1], r_sample} - {r_x[DATA_W-1], r_x};

    always_comb begin
        w_div_req.start = (r_state == ST_GO);
        w_div_req.num   = r_p1;
        w_div_req.den   = {1'b0, r_p1} + {1'b0, r_meas_noise};
    end

    skf_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (w_div_req),
        .o_done  (w_div_done),
        .o_quot  (w_div_quot)
    );

    always_comb begin
        if (r_state == ST_MUL1) begin
            w_mul_a = {w_diff[DATA_W], w_diff};
            w_mul_b = {1'b0, r_gain};
        end else begin
            w_mul_a = {2'b00, r_p1};
            w_mul_b = {1'b0, GAIN_ONE - r_gain};
        end
    end

    skf_mul u_mul (
        .i_clk (i_clk),
        .i_a   (w_mul_a),
        .i_b   (w_mul_b),
        .o_p   (w_mul_p)
    );

    assign w_p_new     = w_mul_p[GAIN_BITS +: DATA_W];
    assign w_in_accept = i_s_axis_tvalid && o_s_axis_tready;
    assign w_out_fire  = (r_state == ST_FIN) && (!r_out_valid || i_m_axis_tready);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= ST_IDLE;
            r_out_valid  <= 1'b0;
            r_init_est   <= RST_INIT_EST;
            r_init_cov   <= RST_INIT_COV;
            r_proc_noise <= RST_PROC_NOISE;
            r_meas_noise <= RST_MEAS_NOISE;
            r_x          <= RST_INIT_EST;
            r_p          <= RST_INIT_COV;
        end else begin
            if (w_out_fire) begin
                r_out_valid <= 1'b1;
            end else if (r_out_valid && i_m_axis_tready) begin
                r_out_valid <= 1'b0;
            end
            unique case (r_state)
                ST_IDLE: begin
                    if (w_in_accept) begin
                        r_sample <= i_s_axis_tdata[DATA_W-1:0];
                        r_state  <= ST_PRED;
                    end
                end
                ST_PRED: begin
                    r_p1    <= w_p1_sat;
                    r_state <= ST_GO;
                end
                ST_GO: begin
                    r_state <= ST_DIV;
                end
                ST_DIV: begin
                    if (w_div_done) begin
                        r_gain  <= w_div_quot;
                        r_state <= ST_MUL1;
                    end
                end
                ST_MUL1: begin
                    r_state <= ST_MUL2;
                end
                ST_MUL2: begin
                    r_x_new <= r_x + w_mul_p[GAIN_BITS +: DATA_W];
                    r_state <= ST_FIN;
                end
                ST_FIN: begin
                    if (w_out_fire) begin
                        r_out_data  <= {7'd0, r_gain, w_p_new, r_x_new};
                        r_x         <= r_x_new;
                        r_p         <= w_p_new;
                        r_state     <= ST_IDLE;
                    end
                end
                default: r_state <= ST_IDLE;
            endcase
            if (i_cfg_we) begin
                unique case (i_cfg_idx)
                    REG_INIT_EST: begin
                        r_init_est <= i_cfg_data;
                        r_x        <= i_cfg_data;
                        r_p        <= r_init_cov;
                    end
                    REG_INIT_COV: begin
                        r_init_cov <= i_cfg_data;
                        r_x        <= r_init_est;
                        r_p        <= i_cfg_data;
                    end
                    REG_PROC_NOISE: begin
                        r_proc_noise <= i_cfg_data;
                        r_x          <= r_init_est;
                        r_p          <= r_init_cov;
                    end
                    REG_MEAS_NOISE: begin
                        r_meas_noise <= i_cfg_data;
                        r_x          <= r_init_est;
                        r_p          <= r_init_cov;
                    end
                endcase
            end
        end
    end

    assign o_s_axis_tready = (r_state == ST_IDLE);
    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = r_out_data;

    `SKF_ASSERT_IMP(a_div_done_in_div, w_div_done, r_state == ST_DIV, "divider done outside DIV")
    `SKF_ASSERT_IMP(a_gain_range, o_m_axis_tvalid, o_m_axis_tdata[80:64] <= GAIN_ONE, "gain above one")
    `SKF_ASSERT_IMP(a_out_from_fin, $rose(r_out_valid), $past(r_state) == ST_FIN, "result not from FIN")

endmodule

// ----- sv/skf_div.sv -----
module skf_div (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  skf_pkg::t_div_req             i_req,
    output logic                          o_done,
    output logic [skf_pkg::GAIN_W-1:0]    o_quot
);
    import skf_pkg::*;

    localparam int STEPS = GAIN_W;
    localparam int CNT_W = $clog2(STEPS + 1);

    logic [DATA_W+1:0] r_rem;
    logic [DATA_W:0]   r_den;
    logic [GAIN_W-1:0] r_quot;
    logic [CNT_W-1:0]  r_cnt;
    logic              r_busy;
    logic              r_done;
    logic              r_zero;

    logic              w_fits;
    logic [DATA_W+1:0] w_diff;

    assign w_fits = r_rem >= {1'b0, r_den};
    assign w_diff = r_rem - (w_fits ? {1'b0, r_den} : '0);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (i_req.start) begin
                r_rem  <= {2'b00, i_req.num};
                r_den  <= i_req.den;
                r_zero <= (i_req.den == '0);
                r_quot <= '0;
                r_cnt  <= CNT_W'(STEPS);
                r_busy <= 1'b1;
            end else if (r_busy) begin
                r_rem  <= {w_diff[DATA_W:0], 1'b0};
                r_quot <= {r_quot[GAIN_W-2:0], w_fits};
                r_cnt  <= r_cnt - 1'b1;
                if (r_cnt == CNT_W'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    assign o_done = r_done;
    assign o_quot = r_zero ? '0 : r_quot;

endmodule

// ----- sv/skf_mul.sv -----
module skf_mul (
    input  logic                                 i_clk,
    input  logic signed [skf_pkg::MUL_A_W-1:0]   i_a,
    input  logic signed [skf_pkg::MUL_B_W-1:0]   i_b,
    output logic signed [skf_pkg::MUL_P_W-1:0]   o_p
);
    import skf_pkg::*;

    logic signed [MUL_P_W-1:0] r_p;

    always_ff @(posedge i_clk) begin
        r_p <= i_a * i_b;
    end

    assign o_p = r_p;

endmodule

// ----- tb/scalar_kalman_filter_unit_tb.sv -----
`timescale 1ns / 1ps

module scalar_kalman_filter_unit_tb;
    import skf_pkg::*;

    localparam int PAD_LO         = 2 * DATA_W + GAIN_W;
    localparam int SETTLE_CYCLES  = 32;
    localparam int WATCHDOG_LIMIT = 5000;
    localparam int LONG_HOLD      = 400;
    localparam int RAND_PHASES    = 8;
    localparam int PHASE_ITEMS    = 100;

    typedef struct packed {
        logic [DATA_W-1:0] est;
        logic [DATA_W-1:0] cov;
        logic [GAIN_W-1:0] gain;
    } t_kf_result;

    logic                   i_clk    = 1'b0;
    logic                   i_rst_n  = 1'b0;
    logic                   s_tvalid = 1'b0;
    logic                   s_tready;
    logic [IN_TDATA_W-1:0]  s_tdata  = '0;
    logic                   m_tvalid;
    logic                   m_tready = 1'b0;
    logic [OUT_TDATA_W-1:0] m_tdata;
    logic                   cfg_we   = 1'b0;
    logic [CFG_IDX_W-1:0]   cfg_idx  = REG_INIT_EST;
    logic [DATA_W-1:0]      cfg_data = '0;

    // filter settings and state as the block should hold them
    logic [DATA_W-1:0] init_est = RST_INIT_EST;
    logic [DATA_W-1:0] init_cov = RST_INIT_COV;
    logic [DATA_W-1:0] q_noise  = RST_PROC_NOISE;
    logic [DATA_W-1:0] r_noise  = RST_MEAS_NOISE;
    logic [DATA_W-1:0] kf_est   = RST_INIT_EST;
    logic [DATA_W-1:0] kf_cov   = RST_INIT_COV;

    logic [DATA_W-1:0] sample_q[$];
    t_kf_result        pending_results[$];

    bit tx_gaps_on = 1'b1;
    bit rx_gaps_on = 1'b1;
    int tx_gap     = 0;
    int rx_gap     = 0;
    int hold_cnt   = 0;
    int idle_cnt   = 0;
    int n_samples  = 0;
    int n_results  = 0;
    int n_errors   = 0;
    int n_cfg      = 0;
    int n_settings = 0;

    scalar_kalman_filter_unit dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_s_axis_tvalid (s_tvalid),
        .o_s_axis_tready (s_tready),
        .i_s_axis_tdata  (s_tdata),
        .o_m_axis_tvalid (m_tvalid),
        .i_m_axis_tready (m_tready),
        .o_m_axis_tdata  (m_tdata),
        .i_cfg_we        (cfg_we),
        .i_cfg_idx       (cfg_idx),
        .i_cfg_data      (cfg_data)
    );

    always #5 i_clk = ~i_clk;

    function automatic t_kf_result kalman_step(input logic [DATA_W-1:0] meas);
        t_kf_result      r;
        longint unsigned p1, den, g, pnew;
        longint          x, diff, corr;
        p1 = 64'(kf_cov) + 64'(q_noise);
        if (p1 > 64'hFFFF_FFFF) begin
            p1 = 64'hFFFF_FFFF;
        end
        den = p1 + 64'(r_noise);
        g = (den == 0) ? 64'd0 : (p1 << GAIN_BITS) / den;
        x = longint'(signed'(kf_est));
        diff = longint'(signed'(meas)) - x;
        corr = (diff * longint'(g)) >>> GAIN_BITS;
        x = x + corr;
        pnew = (p1 * (64'(GAIN_ONE) - g)) >> GAIN_BITS;
        kf_est = 32'(x);
        kf_cov = 32'(pnew);
        r.est = kf_est;
        r.cov = kf_cov;
        r.gain = GAIN_W'(g);
        return r;
    endfunction

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55) return 0;
        if (r < 85) return $urandom_range(1, 3);
        if (r < 97) return $urandom_range(4, 12);
        return $urandom_range(20, 80);
    endfunction

    function automatic logic [DATA_W-1:0] gen_sample(input logic [DATA_W-1:0] truth);
        int r;
        int amp;
        r = $urandom_range(0, 99);
        amp = 1 << $urandom_range(2, 20);
        if (r < 70) return truth + DATA_W'($urandom_range(0, 2 * amp)) - DATA_W'(amp);
        if (r < 85) return $urandom;
        if (r < 92) return $urandom_range(0, 1) ? 32'h7FFF_FFFF : 32'h8000_0000;
        return DATA_W'($urandom_range(0, 64)) - 32'd32;
    endfunction

    function automatic logic [DATA_W-1:0] gen_noise();
        int r;
        r = $urandom_range(0, 9);
        if (r == 0) return '0;
        if (r == 1) return 32'hFFFF_FFFF;
        if (r < 6) return $urandom_range(0, 32'h0004_0000);
        if (r < 8) return $urandom;
        return 32'd1 << $urandom_range(0, 31);
    endfunction

    task automatic add_sample(input logic [DATA_W-1:0] val);
        sample_q = {sample_q, val};
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [DATA_W-1:0] val);
        @(posedge i_clk);
        cfg_we   <= 1'b1;
        cfg_idx  <= idx;
        cfg_data <= val;
        case (idx)
            REG_INIT_EST:   init_est = val;
            REG_INIT_COV:   init_cov = val;
            REG_PROC_NOISE: q_noise  = val;
            REG_MEAS_NOISE: r_noise  = val;
            default: ;
        endcase
        kf_est = init_est;
        kf_cov = init_cov;
        n_cfg++;
        @(posedge i_clk);
        cfg_we <= 1'b0;
    endtask

    task automatic program_filter(input logic [DATA_W-1:0] est, input logic [DATA_W-1:0] cov,
                                  input logic [DATA_W-1:0] qn, input logic [DATA_W-1:0] rn);
        write_reg(REG_INIT_EST, est);
        write_reg(REG_INIT_COV, cov);
        write_reg(REG_PROC_NOISE, qn);
        write_reg(REG_MEAS_NOISE, rn);
        n_settings++;
    endtask

    task automatic settle();
        while (sample_q.size() != 0 || s_tvalid || pending_results.size() != 0) begin
            @(posedge i_clk);
        end
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    // driver
    always @(posedge i_clk) begin
        t_kf_result exp_res;
        if (!i_rst_n) begin
            s_tvalid <= 1'b0;
        end else begin
            if (s_tvalid && s_tready) begin
                exp_res = kalman_step(s_tdata);
                pending_results = {pending_results, exp_res};
                n_samples++;
            end
            if (!(s_tvalid && !s_tready)) begin
                if (tx_gap > 0) begin
                    tx_gap--;
                    s_tvalid <= 1'b0;
                end else if (sample_q.size() != 0) begin
                    s_tvalid <= 1'b1;
                    s_tdata  <= sample_q.pop_front();
                    tx_gap = tx_gaps_on ? pick_gap() : 0;
                end else begin
                    s_tvalid <= 1'b0;
                end
            end
        end
    end

    // monitor and checker
    always @(posedge i_clk) begin
        t_kf_result        want;
        logic [DATA_W-1:0] got_est, got_cov;
        logic [GAIN_W-1:0] got_gain;
        logic [OUT_TDATA_W-PAD_LO-1:0] got_pad;
        if (!i_rst_n) begin
            m_tready <= 1'b0;
        end else begin
            if (m_tvalid && m_tready) begin
                got_est  = m_tdata[DATA_W-1:0];
                got_cov  = m_tdata[2*DATA_W-1:DATA_W];
                got_gain = m_tdata[PAD_LO-1:2*DATA_W];
                got_pad  = m_tdata[OUT_TDATA_W-1:PAD_LO];
                n_results++;
                if (pending_results.size() == 0) begin
                    n_errors++;
                    if (n_errors <= 10) begin
                        $display("ERROR: unexpected result est=%h cov=%h gain=%h",
                                 got_est, got_cov, got_gain);
                    end
                end else begin
                    want = pending_results.pop_front();
                    if (got_est !== want.est || got_cov !== want.cov ||
                        got_gain !== want.gain || got_pad !== '0) begin
                        n_errors++;
                        if (n_errors <= 10) begin
                            $display("ERROR: result %0d exp est=%h cov=%h gain=%h pad=0",
                                     n_results, want.est, want.cov, want.gain);
                            $display("       got est=%h cov=%h gain=%h pad=%h",
                                     got_est, got_cov, got_gain, got_pad);
                        end
                    end
                end
                // long back-pressure so the block stalls its input
                if (n_results % 300 == 150) begin
                    hold_cnt = LONG_HOLD;
                end
            end
            if (hold_cnt > 0) begin
                hold_cnt--;
                m_tready <= 1'b0;
            end else if (rx_gap > 0) begin
                rx_gap--;
                m_tready <= 1'b0;
            end else if (rx_gaps_on && $urandom_range(0, 7) == 0) begin
                rx_gap = pick_gap();
                m_tready <= 1'b0;
            end else begin
                m_tready <= 1'b1;
            end
        end
    end

    always @(posedge i_clk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
            idle_cnt <= 0;
        end else if (idle_cnt >= WATCHDOG_LIMIT) begin
            $display("Timeout: no transaction for %0d cycles", WATCHDOG_LIMIT);
            $display("FAILURE");
            $finish;
        end else begin
            idle_cnt <= idle_cnt + 1;
        end
    end

    initial begin
        logic [DATA_W-1:0] truth;
        logic [DATA_W-1:0] est0;
        int                r;
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        n_settings = 1;

        // reset settings, sample extremes
        add_sample(32'h0000_0000);
        add_sample(32'h7FFF_FFFF);
        add_sample(32'h8000_0000);
        add_sample(32'h0000_0001);
        add_sample(32'hFFFF_FFFF);
        add_sample(32'h0001_0000);
        add_sample(32'hFFFF_0000);
        settle();

        // zero denominator
        program_filter(32'h7FFF_FFFF, 32'h0, 32'h0, 32'h0);
        add_sample(32'h8000_0000);
        add_sample(32'h7FFF_FFFF);
        add_sample(32'h0000_0000);
        settle();

        // zero measurement noise
        program_filter(32'h8000_0000, 32'h0001_0000, 32'h0000_0100, 32'h0);
        add_sample(32'h7FFF_FFFF);
        add_sample(32'h8000_0000);
        add_sample(32'h1234_5678);
        add_sample(32'hEDCB_A988);
        settle();

        // covariance saturation
        program_filter(32'h8000_0000, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        add_sample(32'h7FFF_FFFF);
        add_sample(32'h7FFF_FFFF);
        add_sample(32'h8000_0000);
        add_sample(32'h0000_0000);
        settle();

        for (int ph = 0; ph < RAND_PHASES; ph++) begin
            tx_gaps_on = (ph % 3 != 1);
            rx_gaps_on = (ph % 4 != 2);
            truth = $urandom;
            r = $urandom_range(0, 9);
            if (r < 2) begin
                est0 = 32'h8000_0000;
            end else if (r < 4) begin
                est0 = 32'h7FFF_FFFF;
            end else if (r < 6) begin
                est0 = '0;
            end else begin
                est0 = $urandom;
            end
            program_filter(est0, gen_noise(), gen_noise(), gen_noise());
            for (int k = 0; k < PHASE_ITEMS; k++) begin
                add_sample(gen_sample(truth));
            end
            settle();
        end

        $display("Filtered %0d samples under %0d filter settings (%0d register writes),",
                 n_samples, n_settings, n_cfg);
        $display("checked %0d results with random stalls and long back-pressure.", n_results);
        if (n_errors == 0 && pending_results.size() == 0) begin
            $display("SUCCESS");
        end else begin
            $display("%0d errors, %0d results missing", n_errors, pending_results.size());
            $display("FAILURE");
        end
        $finish;
    end

endmodule
